/* src/psfr_pkg.sv */
// ----------------------------------------------------------------------------
// Particle sensor frame receiver package
// Frame layout constants and the frame-end record shared by the front part,
// the frame queue and the back part.
// ----------------------------------------------------------------------------
package psfr_pkg;

  // Total frame length in bytes, header and checksum included (12 to 64).
  localparam int FRAME_BYTES = 32;

  localparam int POS_W = $clog2(FRAME_BYTES);

  // Position of the high checksum byte and of the last byte of a frame.
  localparam logic [POS_W-1:0] CSUM_POS = POS_W'(FRAME_BYTES - 2);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  localparam logic [7:0] HDR_FIRST  = 8'h42;
  localparam logic [7:0] HDR_SECOND = 8'h4D;

  // The three concentration words occupy bytes PM_FIRST_POS onward, big-endian.
  localparam int PM_WORDS     = 3;
  localparam int PM_FIRST_POS = 4;

  // Queue depth between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic        ok;
    logic [15:0] pm10;
    logic [15:0] pm2_5;
    logic [15:0] pm1;
  } frame_t;

endpackage

/* src/psfr_front.sv */
// ----------------------------------------------------------------------------
// Particle sensor frame receiver, front part
// Hunts for the frame header, tracks the byte position, accumulates the
// checksum and stages the concentration words. Emits one record per frame end.
// ----------------------------------------------------------------------------
module psfr_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            byte_valid_i,
  input  logic [7:0]      rx_byte_i,
  output logic            frame_valid_o,
  output psfr_pkg::frame_t frame_o
);

  logic [psfr_pkg::POS_W-1:0] pos_q, pos_d;
  logic [15:0]                sum_q, sum_d;
  logic [7:0]                 csum_hi_q, csum_hi_d;
  logic [15:0]                staged_q [psfr_pkg::PM_WORDS];
  logic [15:0]                staged_d [psfr_pkg::PM_WORDS];
  logic [15:0]                byte_ext;

  assign byte_ext = {8'h00, rx_byte_i};

  always_comb begin
    pos_d         = pos_q;
    sum_d         = sum_q;
    csum_hi_d     = csum_hi_q;
    staged_d      = staged_q;
    frame_valid_o = 1'b0;
    frame_o.ok    = ({csum_hi_q, rx_byte_i} == sum_q);
    frame_o.pm1   = staged_q[0];
    frame_o.pm2_5 = staged_q[1];
    frame_o.pm10  = staged_q[2];
    if (byte_valid_i) begin
      priority if (pos_q == '0) begin
        if (rx_byte_i == psfr_pkg::HDR_FIRST) begin
          sum_d = byte_ext;
          pos_d = psfr_pkg::POS_W'(1);
        end
      end else if (pos_q == psfr_pkg::POS_W'(1)) begin
        if (rx_byte_i == psfr_pkg::HDR_SECOND) begin
          sum_d = sum_q + byte_ext;
          pos_d = psfr_pkg::POS_W'(2);
        end else if (rx_byte_i == psfr_pkg::HDR_FIRST) begin
          // A repeated first header byte restarts the header.
          sum_d = byte_ext;
        end else begin
          pos_d = '0;
        end
      end else if (pos_q < psfr_pkg::CSUM_POS) begin
        sum_d = sum_q + byte_ext;
        for (int k = 0; k < psfr_pkg::PM_WORDS; k++) begin
          if (pos_q == psfr_pkg::POS_W'(psfr_pkg::PM_FIRST_POS + 2 * k)) begin
            staged_d[k][15:8] = rx_byte_i;
          end
          if (pos_q == psfr_pkg::POS_W'(psfr_pkg::PM_FIRST_POS + 2 * k + 1)) begin
            staged_d[k][7:0] = rx_byte_i;
          end
        end
        pos_d = pos_q + psfr_pkg::POS_W'(1);
      end else if (pos_q == psfr_pkg::CSUM_POS) begin
        csum_hi_d = rx_byte_i;
        pos_d     = pos_q + psfr_pkg::POS_W'(1);
      end else begin
        frame_valid_o = 1'b1;
        pos_d         = '0;
        sum_d         = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      sum_q     <= '0;
      csum_hi_q <= '0;
    end else begin
      pos_q     <= pos_d;
      sum_q     <= sum_d;
      csum_hi_q <= csum_hi_d;
    end
  end

  always_ff @(posedge clk_i) begin
    staged_q <= staged_d;
  end

endmodule

/* src/psfr_queue.sv */
// ----------------------------------------------------------------------------
// Particle sensor frame receiver, frame queue
// Short queue of frame-end records between the front and the back part.
// ----------------------------------------------------------------------------
module psfr_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_i,
  input  psfr_pkg::frame_t wr_data_i,
  output logic             full_o,
  input  logic             rd_i,
  output logic             valid_o,
  output psfr_pkg::frame_t rd_data_o
);

  localparam int CNT_W = $clog2(psfr_pkg::QUEUE_DEPTH + 1);

  psfr_pkg::frame_t            mem_q [psfr_pkg::QUEUE_DEPTH];
  logic [psfr_pkg::QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]            count_q;
  logic                        do_wr, do_rd;

  assign full_o    = (count_q == CNT_W'(psfr_pkg::QUEUE_DEPTH));
  assign valid_o   = (count_q != '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_i && !full_o;
  assign do_rd     = rd_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == psfr_pkg::QPTR_W'(psfr_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_q + psfr_pkg::QPTR_W'(1);
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == psfr_pkg::QPTR_W'(psfr_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_q + psfr_pkg::QPTR_W'(1);
      end
      if (do_wr && !do_rd) begin
        count_q <= count_q + CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

/* src/psfr_back.sv */
// ----------------------------------------------------------------------------
// Particle sensor frame receiver, back part
// Keeps the last verified concentration words and presents one result per
// frame-end record in an output register.
// ----------------------------------------------------------------------------
module psfr_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rec_valid_i,
  input  psfr_pkg::frame_t rec_i,
  output logic             rec_take_o,
  output logic             out_valid_o,
  input  logic             out_pop_i,
  output psfr_pkg::frame_t out_o
);

  logic [15:0]      held_q [psfr_pkg::PM_WORDS];
  logic             out_valid_q;
  psfr_pkg::frame_t out_q, out_d;

  assign rec_take_o  = rec_valid_i && (!out_valid_q || out_pop_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // A failed frame reports the words of the last verified frame.
  always_comb begin
    out_d.ok = rec_i.ok;
    if (rec_i.ok) begin
      out_d.pm1   = rec_i.pm1;
      out_d.pm2_5 = rec_i.pm2_5;
      out_d.pm10  = rec_i.pm10;
    end else begin
      out_d.pm1   = held_q[0];
      out_d.pm2_5 = held_q[1];
      out_d.pm10  = held_q[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      held_q[0]   <= '0;
      held_q[1]   <= '0;
      held_q[2]   <= '0;
    end else begin
      if (rec_take_o) begin
        out_valid_q <= 1'b1;
        held_q[0]   <= out_d.pm1;
        held_q[1]   <= out_d.pm2_5;
        held_q[2]   <= out_d.pm10;
      end else if (out_pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rec_take_o) begin
      out_q <= out_d;
    end
  end

endmodule

/* src/particle_sensor_frame_receiver_top.sv */
// ----------------------------------------------------------------------------
// Particle sensor frame receiver
// Parses 32-byte sensor frames from a serial byte stream and reports the
// PM1.0, PM2.5 and PM10 words with a checksum verdict at each frame end.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle unless full; full rises only when three frame
// results wait unread: the two-entry queue and output register are all taken.
// Result path: a frame's result is written into the frame queue as its last
// byte is accepted, then into the output register when it is free or popped.
// Reset: asynchronous, active low; it clears the header hunt, the checksum,
// the held words, the queue and the output valid flag.
// ----------------------------------------------------------------------------
module particle_sensor_frame_receiver_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  rx_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] pm1_value_o,
  output logic [15:0] pm2_5_value_o,
  output logic [15:0] pm10_value_o,
  output logic        frame_ok_o
);

  logic             byte_valid;
  logic             front_valid;
  psfr_pkg::frame_t front_rec;
  logic             q_full, q_valid, q_take;
  psfr_pkg::frame_t q_rec;
  logic             out_valid;
  psfr_pkg::frame_t out_rec;

  assign full       = q_full;
  assign byte_valid = push && !q_full;

  psfr_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .byte_valid_i  (byte_valid),
    .rx_byte_i     (rx_byte_i),
    .frame_valid_o (front_valid),
    .frame_o       (front_rec)
  );

  psfr_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (front_valid),
    .wr_data_i (front_rec),
    .full_o    (q_full),
    .rd_i      (q_take),
    .valid_o   (q_valid),
    .rd_data_o (q_rec)
  );

  psfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rec_valid_i (q_valid),
    .rec_i       (q_rec),
    .rec_take_o  (q_take),
    .out_valid_o (out_valid),
    .out_pop_i   (pop),
    .out_o       (out_rec)
  );

  assign empty         = !out_valid;
  assign pm1_value_o   = out_rec.pm1;
  assign pm2_5_value_o = out_rec.pm2_5;
  assign pm10_value_o  = out_rec.pm10;
  assign frame_ok_o    = out_rec.ok;

endmodule
